// ===== hdl/lph_pkg.sv =====
`timescale 1ns / 1ps

package lph_pkg;

    // Field widths fixed by the request and result formats
    localparam int MODE_W   = 2;
    localparam int KEY_W    = 32;
    localparam int HASH_W   = 32;
    localparam int VAL_W    = 64;
    localparam int STAT_W   = 3;
    localparam int CFG_W    = 8;
    localparam int CNT_W    = 9;

    // Limit register value after reset
    localparam logic [CFG_W-1:0] MAX_USED_RESET = 8'd192;

    // Request modes
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_GET    = 2'd2;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_INSERTED  = 3'd0;
    localparam logic [STAT_W-1:0] STAT_UPDATED   = 3'd1;
    localparam logic [STAT_W-1:0] STAT_FOUND     = 3'd2;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 3'd3;
    localparam logic [STAT_W-1:0] STAT_REMOVED   = 3'd4;
    localparam logic [STAT_W-1:0] STAT_FULL      = 3'd5;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [KEY_W-1:0]  key_id;
        logic [HASH_W-1:0] key_hash;
        logic [VAL_W-1:0]  value_in;
    } lph_req_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [VAL_W-1:0]  value_out;
    } lph_rsp_t;

    // Slot store controls from the sequencer
    typedef struct packed {
        logic rd_en;
        logic kv_we;
        logic flag_we;
        logic wr_live;
        logic wr_tomb;
    } lph_mem_ctl_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_PROBE,
        ST_DONE
    } lph_state_t;

endpackage

// ===== hdl/lph_hash_mod.sv =====
`timescale 1ns / 1ps

module lph_hash_mod #(
    parameter int CAPACITY = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [lph_pkg::HASH_W-1:0]    hash,
    output logic                          done,
    output logic [$clog2(CAPACITY)-1:0]   rem
);

    localparam int IDX_W   = $clog2(CAPACITY);
    localparam bit IS_POW2 = ((CAPACITY & (CAPACITY - 1)) == 0);

    logic             done_reg, done_next;
    logic [IDX_W-1:0] rem_reg, rem_next;

    generate
        if (IS_POW2) begin : g_mask
            // Power-of-two capacity: keep the low hash bits
            always_comb
            begin
                done_next = start;
                rem_next  = start ? hash[IDX_W-1:0] : rem_reg;
            end
        end else begin : g_recip
            localparam int HW = lph_pkg::HASH_W;
            localparam int SH = HW + IDX_W;
            localparam int QW = 2 * HW + 1 - SH;
            // floor(2^SH / CAPACITY) lies between 2^HW and 2^(HW+1); keep the low word
            localparam logic [63:0]    RECIP    = (64'd1 << SH) / 64'(CAPACITY);
            localparam logic [HW-1:0]  RECIP_LO = HW'(RECIP);
            localparam logic [IDX_W:0] CAP_EXT  = (IDX_W+1)'(CAPACITY);

            logic [2*HW:0]   prod_reg, prod_next;
            logic [HW-1:0]   hold_reg, hold_next;
            logic [IDX_W:0]  diff_reg, diff_next;
            logic            v1_reg;
            logic            v2_reg;
            logic [2*HW-1:0] lo_prod;
            logic [QW-1:0]   quot;
            logic [HW:0]     qc;
            logic [HW:0]     diff_full;

            // Estimate the quotient by reciprocal; it is exact or one low,
            // so one compare and subtract finishes the remainder
            always_comb
            begin
                // 32 by 32 product, upper operand bits are zero
                lo_prod   = (2*HW)'(hash) * (2*HW)'(RECIP_LO);
                prod_next = start ? ({1'b0, hash, {HW{1'b0}}} + {1'b0, lo_prod}) : prod_reg;
                hold_next = start ? hash : hold_reg;
                quot      = prod_reg[2*HW:SH];
                qc        = (HW+1)'(quot) * (HW+1)'(CAPACITY);
                diff_full = {1'b0, hold_reg} - qc;
                diff_next = diff_full[IDX_W:0];
                rem_next  = rem_reg;
                if (v2_reg)
                begin
                    rem_next = (diff_reg >= CAP_EXT) ? IDX_W'(diff_reg - CAP_EXT)
                                                     : diff_reg[IDX_W-1:0];
                end
                done_next = v2_reg;
            end

            // Advance the stage valid bits
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v1_reg <= 1'b0;
                    v2_reg <= 1'b0;
                end else
                begin
                    v1_reg <= start;
                    v2_reg <= v1_reg;
                end
            end

            always_ff @(posedge clk)
            begin
                prod_reg <= prod_next;
                hold_reg <= hold_next;
                diff_reg <= diff_next;
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

// ===== hdl/lph_slot_store.sv =====
`timescale 1ns / 1ps

module lph_slot_store #(
    parameter int CAPACITY = 256
) (
    input  logic                         clk,
    input  lph_pkg::lph_mem_ctl_t        ctl,
    input  logic [$clog2(CAPACITY)-1:0]  rd_addr,
    input  logic [$clog2(CAPACITY)-1:0]  wr_addr,
    input  logic [lph_pkg::KEY_W-1:0]    wr_key,
    input  logic [lph_pkg::VAL_W-1:0]    wr_value,
    output logic [lph_pkg::KEY_W-1:0]    rd_key,
    output logic [lph_pkg::VAL_W-1:0]    rd_value,
    output logic                         rd_live,
    output logic                         rd_tomb
);

    // Key and value words; contents undefined until written
    logic [lph_pkg::KEY_W-1:0] key_mem [CAPACITY];
    logic [lph_pkg::VAL_W-1:0] val_mem [CAPACITY];
    // Live and tombstone marks; cleared by the sequencer after reset
    logic [1:0]                flag_mem [CAPACITY];

    logic [lph_pkg::KEY_W-1:0] rd_key_reg;
    logic [lph_pkg::VAL_W-1:0] rd_value_reg;
    logic [1:0]                rd_flag_reg;

    // Write key and value together
    always_ff @(posedge clk)
    begin
        if (ctl.kv_we)
        begin
            key_mem[wr_addr] <= wr_key;
            val_mem[wr_addr] <= wr_value;
        end
    end

    // Write slot marks
    always_ff @(posedge clk)
    begin
        if (ctl.flag_we)
        begin
            flag_mem[wr_addr] <= {ctl.wr_live, ctl.wr_tomb};
        end
    end

    // Registered read
    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_key_reg   <= key_mem[rd_addr];
            rd_value_reg <= val_mem[rd_addr];
            rd_flag_reg  <= flag_mem[rd_addr];
        end
    end

    assign rd_key   = rd_key_reg;
    assign rd_value = rd_value_reg;
    assign rd_live  = rd_flag_reg[1];
    assign rd_tomb  = rd_flag_reg[0];

endmodule

// ===== hdl/linear_probe_hash_table_core.sv =====
`timescale 1ns / 1ps

// Channel   Ports                  Beat taken when
// request   start, busy, req       start && !busy at a rising edge
// result    done, rsp              done high (one cycle, no back-pressure)
// config    cfg_we, cfg_data       cfg_we high at a rising edge
//
// Each request runs the hash step (the low hash bits for a power-of-two CAPACITY,
// else the reciprocal hash remainder pipeline), probes slots one per cycle through
// the registered slot memory read, then takes the update state and shows its result.
// The result strobe follows the last busy cycle; one request is in work at a time.
// After reset the slot marks are swept clear, one slot a cycle, with busy high
// throughout the sweep. The result side cannot stall; each result shows once.

module linear_probe_hash_table_core #(
    parameter int CAPACITY = 256
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  lph_pkg::lph_req_t          req,
    output logic                       done,
    output lph_pkg::lph_rsp_t          rsp,
    input  logic                       cfg_we,
    input  logic [lph_pkg::CFG_W-1:0]  cfg_data
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam logic [IDX_W-1:0] CAP_M1 = IDX_W'(CAPACITY - 1);

    lph_pkg::lph_state_t state_reg, state_next;

    lph_pkg::lph_req_t           req_reg, req_next;
    logic [IDX_W-1:0]            probe_addr_reg, probe_addr_next;
    logic [IDX_W-1:0]            probe_cnt_reg, probe_cnt_next;
    logic [IDX_W-1:0]            clear_addr_reg, clear_addr_next;
    logic                        tomb_seen_reg, tomb_seen_next;
    logic [IDX_W-1:0]            tomb_addr_reg, tomb_addr_next;
    logic                        hit_reg, hit_next;
    logic                        have_slot_reg, have_slot_next;
    logic                        is_tomb_reg, is_tomb_next;
    logic [IDX_W-1:0]            where_reg, where_next;
    logic [lph_pkg::VAL_W-1:0]   hit_value_reg, hit_value_next;
    logic [lph_pkg::CNT_W-1:0]   used_count_reg, used_count_next;
    logic [lph_pkg::CFG_W-1:0]   max_used_reg, max_used_next;
    logic                        done_reg, done_next;
    lph_pkg::lph_rsp_t           rsp_reg, rsp_next;

    logic                        accept;
    logic                        mod_done;
    logic [IDX_W-1:0]            mod_rem;

    lph_pkg::lph_mem_ctl_t       mem_ctl;
    logic [IDX_W-1:0]            rd_addr;
    logic [IDX_W-1:0]            wr_addr;
    logic [lph_pkg::KEY_W-1:0]   rd_key;
    logic [lph_pkg::VAL_W-1:0]   rd_value;
    logic                        rd_live;
    logic                        rd_tomb;

    logic                        key_match;
    logic                        is_empty;
    logic                        new_tomb;
    logic                        probe_end;
    logic [IDX_W-1:0]            next_addr;
    logic                        room;

    assign accept = start && !busy;

    lph_hash_mod #(
        .CAPACITY (CAPACITY)
    ) u_hash_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .hash  (req.key_hash),
        .done  (mod_done),
        .rem   (mod_rem)
    );

    lph_slot_store #(
        .CAPACITY (CAPACITY)
    ) u_slot_store (
        .clk      (clk),
        .ctl      (mem_ctl),
        .rd_addr  (rd_addr),
        .wr_addr  (wr_addr),
        .wr_key   (req_reg.key_id),
        .wr_value (req_reg.value_in),
        .rd_key   (rd_key),
        .rd_value (rd_value),
        .rd_live  (rd_live),
        .rd_tomb  (rd_tomb)
    );

    // Classify the slot whose read data is on hand
    always_comb
    begin
        key_match = rd_live && (rd_key == req_reg.key_id);
        is_empty  = !rd_live && !rd_tomb;
        new_tomb  = !rd_live && rd_tomb && !tomb_seen_reg;
        probe_end = key_match || is_empty || (probe_cnt_reg == CAP_M1);
        next_addr = (probe_addr_reg == CAP_M1) ? '0 : probe_addr_reg + 1'b1;
        room      = is_tomb_reg || (used_count_reg < {1'b0, max_used_reg});
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lph_pkg::ST_CLEAR:
            begin
                if (clear_addr_reg == CAP_M1)
                begin
                    state_next = lph_pkg::ST_IDLE;
                end
            end
            lph_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = lph_pkg::ST_HASH;
                end
            end
            lph_pkg::ST_HASH:
            begin
                if (mod_done)
                begin
                    state_next = lph_pkg::ST_PROBE;
                end
            end
            lph_pkg::ST_PROBE:
            begin
                if (probe_end)
                begin
                    state_next = lph_pkg::ST_DONE;
                end
            end
            lph_pkg::ST_DONE:
            begin
                state_next = lph_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = lph_pkg::ST_IDLE;
            end
        endcase
    end

    // Memory controls and datapath register updates
    always_comb
    begin
        req_next        = req_reg;
        probe_addr_next = probe_addr_reg;
        probe_cnt_next  = probe_cnt_reg;
        clear_addr_next = clear_addr_reg;
        tomb_seen_next  = tomb_seen_reg;
        tomb_addr_next  = tomb_addr_reg;
        hit_next        = hit_reg;
        have_slot_next  = have_slot_reg;
        is_tomb_next    = is_tomb_reg;
        where_next      = where_reg;
        hit_value_next  = hit_value_reg;
        used_count_next = used_count_reg;
        max_used_next   = cfg_we ? cfg_data : max_used_reg;
        done_next       = 1'b0;
        rsp_next        = rsp_reg;
        mem_ctl         = '0;
        rd_addr         = probe_addr_reg;
        wr_addr         = where_reg;

        case (state_reg)
            lph_pkg::ST_CLEAR:
            begin
                // Sweep the slot marks to empty
                mem_ctl.flag_we = 1'b1;
                wr_addr         = clear_addr_reg;
                clear_addr_next = clear_addr_reg + 1'b1;
            end
            lph_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    req_next       = req;
                    probe_cnt_next = '0;
                    tomb_seen_next = 1'b0;
                end
            end
            lph_pkg::ST_HASH:
            begin
                // Issue the read of the home slot
                if (mod_done)
                begin
                    mem_ctl.rd_en   = 1'b1;
                    rd_addr         = mod_rem;
                    probe_addr_next = mod_rem;
                end
            end
            lph_pkg::ST_PROBE:
            begin
                if (new_tomb)
                begin
                    tomb_seen_next = 1'b1;
                    tomb_addr_next = probe_addr_reg;
                end
                if (probe_end)
                begin
                    // Hold the probe outcome for the update cycle
                    hit_next       = key_match;
                    have_slot_next = !key_match && (is_empty || tomb_seen_reg || new_tomb);
                    is_tomb_next   = tomb_seen_reg || new_tomb;
                    where_next     = (!key_match && tomb_seen_reg) ? tomb_addr_reg
                                                                   : probe_addr_reg;
                    hit_value_next = rd_value;
                end else
                begin
                    // Advance to the next slot, wrapping at the end
                    mem_ctl.rd_en   = 1'b1;
                    rd_addr         = next_addr;
                    probe_addr_next = next_addr;
                    probe_cnt_next  = probe_cnt_reg + 1'b1;
                end
            end
            lph_pkg::ST_DONE:
            begin
                done_next          = 1'b1;
                rsp_next.value_out = '0;
                rsp_next.status    = lph_pkg::STAT_NOT_FOUND;
                case (req_reg.mode)
                    lph_pkg::MODE_INSERT:
                    begin
                        if (hit_reg)
                        begin
                            mem_ctl.kv_we   = 1'b1;
                            rsp_next.status = lph_pkg::STAT_UPDATED;
                        end else if (have_slot_reg && room)
                        begin
                            mem_ctl.kv_we   = 1'b1;
                            mem_ctl.flag_we = 1'b1;
                            mem_ctl.wr_live = 1'b1;
                            rsp_next.status = lph_pkg::STAT_INSERTED;
                            if (!is_tomb_reg)
                            begin
                                used_count_next = used_count_reg + 1'b1;
                            end
                        end else
                        begin
                            rsp_next.status = lph_pkg::STAT_FULL;
                        end
                    end
                    lph_pkg::MODE_REMOVE:
                    begin
                        if (hit_reg)
                        begin
                            mem_ctl.flag_we = 1'b1;
                            mem_ctl.wr_tomb = 1'b1;
                            rsp_next.status = lph_pkg::STAT_REMOVED;
                        end
                    end
                    lph_pkg::MODE_GET:
                    begin
                        if (hit_reg)
                        begin
                            rsp_next.status    = lph_pkg::STAT_FOUND;
                            rsp_next.value_out = hit_value_reg;
                        end
                    end
                    default:
                    begin
                        rsp_next.status = lph_pkg::STAT_NOT_FOUND;
                    end
                endcase
            end
            default:
            begin
                mem_ctl = '0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= lph_pkg::ST_CLEAR;
            clear_addr_reg <= '0;
            used_count_reg <= '0;
            max_used_reg   <= lph_pkg::MAX_USED_RESET;
            done_reg       <= 1'b0;
        end else
        begin
            state_reg      <= state_next;
            clear_addr_reg <= clear_addr_next;
            used_count_reg <= used_count_next;
            max_used_reg   <= max_used_next;
            done_reg       <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        probe_addr_reg <= probe_addr_next;
        probe_cnt_reg  <= probe_cnt_next;
        tomb_seen_reg  <= tomb_seen_next;
        tomb_addr_reg  <= tomb_addr_next;
        hit_reg        <= hit_next;
        have_slot_reg  <= have_slot_next;
        is_tomb_reg    <= is_tomb_next;
        where_reg      <= where_next;
        hit_value_reg  <= hit_value_next;
        rsp_reg        <= rsp_next;
    end

    assign busy = (state_reg != lph_pkg::ST_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    a_done_after_update: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == lph_pkg::ST_DONE))
        else $error("result strobe without an update cycle");

    a_accept_starts_hash: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (state_reg == lph_pkg::ST_HASH))
        else $error("accepted request did not start the hash step");

    a_used_never_falls: assert property (@(posedge clk) disable iff (!rst_n)
        used_count_reg >= $past(used_count_reg))
        else $error("used count fell");

    a_used_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        !used_count_reg[lph_pkg::CNT_W-1])
        else $error("used count passed the limit range");

    a_marks_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        mem_ctl.flag_we |-> !(mem_ctl.wr_live && mem_ctl.wr_tomb))
        else $error("slot written both live and tombstoned");

endmodule
